// ===== hdl/tdes_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdes_pkg
// Shared types, codes and helpers of the timed diagnostics entry sequencer.
// ----------------------------------------------------------------------------
package tdes_pkg;

   localparam int TimeBits    = 32;
   localparam int TimeExtBits = TimeBits + 1;
   localparam int NowBits     = (TimeBits < 32) ? TimeBits : 32;
   localparam int SatBits     = 64;
   localparam int DurBits     = 17;

   localparam logic [DurBits-1:0] HoldExtraMs = 17'd1000;
   localparam logic [DurBits-1:0] ReleaseMs   = 17'd3000;

   localparam logic [1:0] KindTick  = 2'd0;
   localparam logic [1:0] KindStart = 2'd1;
   localparam logic [1:0] KindStop  = 2'd2;

   localparam logic [3:0] StageOff      = 4'd0;
   localparam logic [3:0] StageIgnOff   = 4'd1;
   localparam logic [3:0] StageOffWait  = 4'd2;
   localparam logic [3:0] StageIgnOn    = 4'd3;
   localparam logic [3:0] StageOnWait   = 4'd4;
   localparam logic [3:0] StagePulse    = 4'd5;
   localparam logic [3:0] StageHoldWait = 4'd6;
   localparam logic [3:0] StageHold     = 4'd7;
   localparam logic [3:0] StageRelease  = 4'd8;

   localparam logic [1:0] ErrNone  = 2'd0;
   localparam logic [1:0] ErrCar   = 2'd1;
   localparam logic [1:0] ErrPedal = 2'd2;

   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 16;
   localparam logic [CsrIndexBits-1:0] CsrIgnOffWait   = 3'd0;
   localparam logic [CsrIndexBits-1:0] CsrIgnOnWait    = 3'd1;
   localparam logic [CsrIndexBits-1:0] CsrPulseCount   = 3'd2;
   localparam logic [CsrIndexBits-1:0] CsrPulseInterval = 3'd3;
   localparam logic [CsrIndexBits-1:0] CsrPreHoldWait  = 3'd4;
   localparam logic [CsrIndexBits-1:0] CsrHold         = 3'd5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_ms;
      logic        car_link_ok;
      logic        controller_ok;
      logic        pedal_ok;
      logic        ignition_on;
      logic        moving;
      logic        engine_turning;
      logic        parking_brake_on;
      logic        braking;
   } req_type;

   typedef struct packed {
      logic [3:0] stage;
      logic       pedal_pressed;
      logic       pedal_enabled;
      logic [1:0] error;
   } rsp_type;

   // time plus duration, widened by a carry bit; it saturates at all ones of TimeBits only if TimeBits >= SatBits (64)
   function automatic logic [TimeExtBits-1:0] sat_add(input logic [TimeBits-1:0] a,
                                                      input logic [DurBits-1:0] b);
      logic [TimeExtBits-1:0] sum;
      sum = {1'b0, a} + TimeExtBits'(b);
      if ((TimeBits >= SatBits) && sum[TimeBits]) begin
         sum = {1'b0, {TimeBits{1'b1}}};
      end
      return sum;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/timed_diagnostics_entry_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timed_diagnostics_entry_sequencer
// Event-driven stage sequencer that drives a virtual gas pedal.
// ----------------------------------------------------------------------------
// Each accepted event yields exactly one result. An item can enter every
// cycle while the result side does not stall; it is held in the input
// register and the sequence state is updated as it moves into the result
// register, which presents its result. A stall on the result side holds
// it in the input register. The state is updated once per advancing item,
// with one deadline adder and one pulse-interval adder. Configuration writes
// take effect at once and are expected only while no item is in flight.
module timed_diagnostics_entry_sequencer (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_stall,
   input  wire  tdes_pkg::req_type                     req_payload,
   output logic                                        rsp_valid,
   input  wire                                         rsp_stall,
   output tdes_pkg::rsp_type                           rsp_payload,
   input  wire                                         csr_write_en,
   input  wire  [tdes_pkg::CsrIndexBits-1:0]           csr_index,
   input  wire  [tdes_pkg::CsrDataBits-1:0]            csr_wdata
);

   // configuration
   logic [15:0] ign_off_wait_ff, ign_on_wait_ff, pulse_interval_ff;
   logic [15:0] pre_hold_wait_ff, hold_ff;
   logic [6:0]  pulse_count_ff;

   // handshake and payload
   logic              in_valid_ff, in_valid_in;
   tdes_pkg::req_type in_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   tdes_pkg::rsp_type rsp_ff, rsp_in;
   logic              advance, req_take;

   // sequence state
   logic [3:0]                       stage_ff, stage_in;
   logic [3:0]                       seen_ff, seen_in;
   logic [tdes_pkg::TimeExtBits-1:0] wait_end_ff, wait_end_in;
   logic [tdes_pkg::TimeBits-1:0]    pulse_start_ff, pulse_start_in;
   logic [6:0]                       pulses_done_ff, pulses_done_in;
   logic                             level_ff, level_in;
   logic                             enable_ff, enable_in;

   // evaluation
   logic [tdes_pkg::TimeBits-1:0]    now_v;
   logic [tdes_pkg::TimeExtBits-1:0] now_ext;
   logic [tdes_pkg::DurBits-1:0]     dur;
   logic [tdes_pkg::TimeExtBits-1:0] armed;
   logic                             wait_hit;
   logic [1:0]                       err;
   logic                             unset;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      now_v   = tdes_pkg::TimeBits'(in_ff.now_ms[tdes_pkg::NowBits-1:0]);
      now_ext = {1'b0, now_v};

      stage_in       = stage_ff;
      seen_in        = seen_ff;
      wait_end_in    = wait_end_ff;
      pulse_start_in = pulse_start_ff;
      pulses_done_in = pulses_done_ff;
      level_in       = level_ff;
      enable_in      = enable_ff;
      err            = tdes_pkg::ErrNone;

      if ((in_ff.kind == tdes_pkg::KindStart) && (stage_in == tdes_pkg::StageOff)) begin
         stage_in = tdes_pkg::StageIgnOff;
      end else if (in_ff.kind == tdes_pkg::KindStop) begin
         stage_in = tdes_pkg::StageOff;
      end

      // clear timers and pulse count on first sight of a new stage; drop the pedal on entering Off
      if (stage_in != seen_in) begin
         if (stage_in == tdes_pkg::StageOff) begin
            enable_in = 1'b0;
            level_in  = 1'b0;
         end
         wait_end_in    = '0;
         pulse_start_in = '0;
         pulses_done_in = '0;
         seen_in        = stage_in;
      end

      case (stage_in)
         tdes_pkg::StageOffWait:  dur = {1'b0, ign_off_wait_ff};
         tdes_pkg::StageOnWait:   dur = {1'b0, ign_on_wait_ff};
         tdes_pkg::StageHoldWait: dur = {1'b0, pre_hold_wait_ff};
         tdes_pkg::StageHold:     dur = {1'b0, hold_ff} + tdes_pkg::HoldExtraMs;
         default:                 dur = tdes_pkg::ReleaseMs;
      endcase
      unset    = (wait_end_in == '0);
      armed    = unset ? tdes_pkg::sat_add(now_v, dur) : wait_end_in;
      wait_hit = (now_ext >= armed);

      if (stage_in == tdes_pkg::StageOff) begin
         err = tdes_pkg::ErrNone;
      end else if (!in_ff.car_link_ok || !in_ff.controller_ok) begin
         stage_in = tdes_pkg::StageOff;
         err      = tdes_pkg::ErrCar;
      end else if (!in_ff.pedal_ok) begin
         stage_in = tdes_pkg::StageOff;
         err      = tdes_pkg::ErrPedal;
      end else begin
         case (stage_in)
            tdes_pkg::StageIgnOff: begin
               level_in  = 1'b0;
               enable_in = 1'b1;
               if (!(in_ff.ignition_on || in_ff.moving || in_ff.engine_turning ||
                     !in_ff.parking_brake_on || in_ff.braking)) begin
                  stage_in = tdes_pkg::StageOffWait;
               end
            end
            tdes_pkg::StageOffWait: begin
               wait_end_in = armed;
               if (wait_hit) begin
                  stage_in = tdes_pkg::StageIgnOn;
               end else if (in_ff.ignition_on) begin
                  stage_in = tdes_pkg::StageIgnOff;
               end
            end
            tdes_pkg::StageIgnOn: begin
               if (in_ff.ignition_on) begin
                  stage_in = tdes_pkg::StageOnWait;
               end
            end
            tdes_pkg::StageOnWait, tdes_pkg::StagePulse, tdes_pkg::StageHoldWait,
            tdes_pkg::StageHold, tdes_pkg::StageRelease: begin
               if (!in_ff.ignition_on || in_ff.engine_turning) begin
                  stage_in = tdes_pkg::StageIgnOff;
               end else if (stage_in == tdes_pkg::StagePulse) begin
                  if (pulses_done_in >= pulse_count_ff) begin
                     level_in = 1'b0;
                     stage_in = tdes_pkg::StageHoldWait;
                  end else if (now_ext >= tdes_pkg::sat_add(pulse_start_in,
                                                          {1'b0, pulse_interval_ff})) begin
                     pulse_start_in = now_v;
                     if (!level_in) begin
                        level_in = 1'b1;
                     end else begin
                        level_in       = 1'b0;
                        pulses_done_in = pulses_done_in + 7'd1;
                     end
                  end
               end else begin
                  if (unset && (stage_in == tdes_pkg::StageHold)) begin
                     level_in = 1'b1;
                  end
                  if (unset && (stage_in == tdes_pkg::StageRelease)) begin
                     level_in  = 1'b0;
                     enable_in = 1'b0;
                  end
                  wait_end_in = armed;
                  if (wait_hit) begin
                     case (stage_in)
                        tdes_pkg::StageOnWait:   stage_in = tdes_pkg::StagePulse;
                        tdes_pkg::StageHoldWait: stage_in = tdes_pkg::StageHold;
                        tdes_pkg::StageHold:     stage_in = tdes_pkg::StageRelease;
                        default:                 stage_in = tdes_pkg::StageOff;
                     endcase
                  end
               end
            end
            default: begin
               err = tdes_pkg::ErrNone;
            end
         endcase
      end

      rsp_in.stage         = stage_in;
      rsp_in.pedal_pressed = level_in;
      rsp_in.pedal_enabled = enable_in;
      rsp_in.error         = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         stage_ff          <= tdes_pkg::StageOff;
         seen_ff           <= tdes_pkg::StageOff;
         wait_end_ff       <= '0;
         pulse_start_ff    <= '0;
         pulses_done_ff    <= '0;
         level_ff          <= 1'b0;
         enable_ff         <= 1'b0;
         ign_off_wait_ff   <= 16'd5000;
         ign_on_wait_ff    <= 16'd3000;
         pulse_count_ff    <= 7'd5;
         pulse_interval_ff <= 16'd500;
         pre_hold_wait_ff  <= 16'd7000;
         hold_ff           <= 16'd10000;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            stage_ff       <= stage_in;
            seen_ff        <= seen_in;
            wait_end_ff    <= wait_end_in;
            pulse_start_ff <= pulse_start_in;
            pulses_done_ff <= pulses_done_in;
            level_ff       <= level_in;
            enable_ff      <= enable_in;
         end
         if (csr_write_en) begin
            case (csr_index)
               tdes_pkg::CsrIgnOffWait:    ign_off_wait_ff   <= csr_wdata;
               tdes_pkg::CsrIgnOnWait:     ign_on_wait_ff    <= csr_wdata;
               tdes_pkg::CsrPulseCount:    pulse_count_ff    <= csr_wdata[6:0];
               tdes_pkg::CsrPulseInterval: pulse_interval_ff <= csr_wdata;
               tdes_pkg::CsrPreHoldWait:   pre_hold_wait_ff  <= csr_wdata;
               tdes_pkg::CsrHold:          hold_ff           <= csr_wdata;
               default:                    hold_ff           <= hold_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire
